// File: hw/rtl/firlp_pkg.sv
// Package for the 81-tap saturating low-pass FIR: format constants and the
// Q1.15 coefficient ROM. No dependencies.
`default_nettype none

package firlp_pkg;

	localparam int TAPS_DEF         = 81;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int COEF_WIDTH       = 16;
	localparam int COEF_FRAC        = 15;
	localparam int COEF_COUNT       = 81;
	localparam int COEF_IDX_W       = $clog2(COEF_COUNT);

	typedef logic signed [COEF_WIDTH-1:0] coef_t;

	localparam coef_t COEF_ROM [COEF_COUNT] = '{
		-16'sd5,    -16'sd8,    -16'sd6,    16'sd4,     16'sd17,
		16'sd21,    16'sd6,     -16'sd22,   -16'sd41,   -16'sd27,
		16'sd21,    16'sd68,    16'sd68,    16'sd3,     -16'sd87,
		-16'sd125,  -16'sd56,   16'sd89,    16'sd195,   16'sd151,
		-16'sd47,   -16'sd258,  -16'sd288,  -16'sd58,   16'sd290,
		16'sd464,   16'sd255,   -16'sd248,  -16'sd661,  -16'sd575,
		16'sd76,    16'sd859,   16'sd1083,  16'sd345,   -16'sd1027,
		-16'sd1996, -16'sd1421, 16'sd1140,  16'sd4953,  16'sd8372,
		16'sd9743,
		16'sd8372,  16'sd4953,  16'sd1140,  -16'sd1421, -16'sd1996,
		-16'sd1027, 16'sd345,   16'sd1083,  16'sd859,   16'sd76,
		-16'sd575,  -16'sd661,  -16'sd248,  16'sd255,   16'sd464,
		16'sd290,   -16'sd58,   -16'sd288,  -16'sd258,  -16'sd47,
		16'sd151,   16'sd195,   16'sd89,    -16'sd56,   -16'sd125,
		-16'sd87,   16'sd3,     16'sd68,    16'sd68,    16'sd21,
		-16'sd27,   -16'sd41,   -16'sd22,   16'sd6,     16'sd21,
		16'sd17,    16'sd4,     -16'sd6,    -16'sd8,    -16'sd5
	};

	// Taps past the stored table weigh zero.
	function automatic coef_t coef_at(input int j);
		logic [COEF_IDX_W-1:0] idx;
		idx = COEF_IDX_W'(j);
		if (j >= 0 && j < COEF_COUNT) begin
			return COEF_ROM[idx];
		end
		return '0;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/firlp_cell.sv
// One tap of the transposed-form FIR chain: multiply the broadcast sample by
// a fixed coefficient and add the partial sum handed over by the next cell.
// Depends on firlp_pkg.
`default_nettype none

module firlp_cell #(
	parameter int                SAMPLE_WIDTH = firlp_pkg::SAMPLE_WIDTH_DEF,
	parameter int                ACC_WIDTH    = 40,
	parameter firlp_pkg::coef_t  COEF         = '0
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic signed [SAMPLE_WIDTH-1:0] x,
	input  wire logic signed [ACC_WIDTH-1:0]    sum_in,
	output logic signed [ACC_WIDTH-1:0]         sum_q
);
	import firlp_pkg::*;

	logic signed [SAMPLE_WIDTH+COEF_WIDTH-1:0] prod;

	assign prod = x * COEF;

	// Partial sums stand for the history; clear them so it starts at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (en) begin
			sum_q <= sum_in + ACC_WIDTH'(prod);
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/firlp_sat.sv
// Output stage: round the full-precision sum to the sample format, clamp it
// and register sample and clip flag. Depends on firlp_pkg.
`default_nettype none

module firlp_sat #(
	parameter int SAMPLE_WIDTH = firlp_pkg::SAMPLE_WIDTH_DEF,
	parameter int ACC_WIDTH    = 40
) (
	input  wire logic                        clk,
	input  wire logic                        load,
	input  wire logic signed [ACC_WIDTH-1:0] acc,
	output logic signed [SAMPLE_WIDTH-1:0]   sample_q,
	output logic                             clip_q
);
	import firlp_pkg::*;

	localparam int QW = ACC_WIDTH - COEF_FRAC;
	localparam logic signed [QW-1:0] HI = {{(QW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [QW-1:0] LO = {{(QW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic signed [ACC_WIDTH-1:0] HALF = ACC_WIDTH'(1) << (COEF_FRAC - 1);

	logic signed [ACC_WIDTH-1:0]    rnd;
	logic signed [QW-1:0]           q;
	logic signed [SAMPLE_WIDTH-1:0] sat;
	logic                           clip;

	// Add half an LSB and floor: ties go toward plus infinity.
	assign rnd = acc + HALF;
	assign q   = rnd[ACC_WIDTH-1:COEF_FRAC];

	always_comb begin
		if (q > HI) begin
			sat  = HI[SAMPLE_WIDTH-1:0];
			clip = 1'b1;
		end else if (q < LO) begin
			sat  = LO[SAMPLE_WIDTH-1:0];
			clip = 1'b1;
		end else begin
			sat  = q[SAMPLE_WIDTH-1:0];
			clip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sample_q <= sat;
			clip_q   <= clip;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/fir_lowpass_81_tap_saturating.sv
// 81-tap symmetric low-pass FIR on Q1.15 samples with a saturating output and
// a clip flag; built from firlp_cell and firlp_sat, constants in firlp_pkg.
// The filter is a transposed chain of multiply-add cells: the accepted sample
// goes to every cell at once and each cell adds its product to the partial
// sum of its right neighbor, so one sample is taken per clock while the output
// is not stalled; the result is registered in the cell chain and then in the
// round-and-clamp stage. The rate is set by the multiply-add in each cell.
// Reset clears the partial sums, which gives an all-zero history; there is no
// clearing pass. Backpressure on the output stalls the whole chain.
`default_nettype none

module fir_lowpass_81_tap_saturating #(
	parameter int TAPS         = firlp_pkg::TAPS_DEF,
	parameter int SAMPLE_WIDTH = firlp_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,  // sample_in
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         m_tdata,  // sample_out
	output logic [0:0]                                m_tuser   // clipped
);
	import firlp_pkg::*;

	localparam int DATA_W    = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int ACC_WIDTH = SAMPLE_WIDTH + COEF_WIDTH + $clog2(TAPS);

	logic signed [SAMPLE_WIDTH-1:0] x;
	logic signed [ACC_WIDTH-1:0]    sums [0:TAPS];
	logic                           in_xfer;
	logic                           out_load;
	logic                           sum_vld_q;
	logic                           out_vld_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic                           clip_q;

	assign x        = s_tdata[SAMPLE_WIDTH-1:0];
	assign out_load = sum_vld_q && (!out_vld_q || m_tready);
	assign s_tready = !sum_vld_q || out_load;
	assign in_xfer  = s_tvalid && s_tready;

	assign sums[TAPS] = '0;

	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		firlp_cell #(
			.SAMPLE_WIDTH (SAMPLE_WIDTH),
			.ACC_WIDTH    (ACC_WIDTH),
			.COEF         (coef_at(k))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (in_xfer),
			.x      (x),
			.sum_in (sums[k+1]),
			.sum_q  (sums[k])
		);
	end

	firlp_sat #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.ACC_WIDTH    (ACC_WIDTH)
	) u_sat (
		.clk      (clk),
		.load     (out_load),
		.acc      (sums[0]),
		.sample_q (sample_q),
		.clip_q   (clip_q)
	);

	// Cell 0 holds a finished sum until the output stage takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				sum_vld_q <= 1'b1;
			end else if (out_load) begin
				sum_vld_q <= 1'b0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = DATA_W'($unsigned(sample_q));
	assign m_tuser  = clip_q;

`ifndef SYNTH
	a_clip_is_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |->
		((m_tdata[SAMPLE_WIDTH-1:0] == {1'b0, {(SAMPLE_WIDTH-1){1'b1}}}) ||
		 (m_tdata[SAMPLE_WIDTH-1:0] == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}})))
		else $error("clip flag set on a sample that is not at a rail");

	a_xfer_fills_sum: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> sum_vld_q)
		else $error("input transfer did not leave a pending sum");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while the output register is empty");

	a_load_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid)
		else $error("sum moved to output stage but no result shown");
`endif

endmodule

`default_nettype wire
